// File: rtl/core/elu_pkg.sv
// Package for the echoing line editor: constants, codes and shared types.
package elu_pkg;

  localparam int LINE_DEPTH_DEF = 256;
  localparam int MAX_LINE_DEF   = 255;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // action codes
  localparam logic [1:0] ACT_RX      = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  // received byte codes
  localparam logic [7:0] CH_CTRL_C   = 8'd3;
  localparam logic [7:0] CH_CTRL_D   = 8'd4;
  localparam logic [7:0] CH_BS       = 8'd8;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_TILDE    = 8'd126;
  localparam logic [7:0] CH_DEL      = 8'd127;

  localparam logic [1:0] LAST_STEP = 2'd2;

  typedef enum logic [1:0] {
    ECHO_NONE,
    ECHO_CHAR,
    ECHO_DEL,
    ECHO_CR
  } echo_kind_t;

  typedef struct packed {
    echo_kind_t  kind;
    logic [7:0]  rx_char;
    logic        rst_req;
    logic        line_ready;
    logic [7:0]  line_len;
    logic        read_ok;
    logic [7:0]  read_data;
  } elu_cmd_t;

  typedef struct packed {
    logic        echo_valid;
    logic [7:0]  echo_byte;
    logic        last;
    logic [7:0]  returned_char;
    logic        line_ready;
    logic [7:0]  line_length;
    logic        reset_request;
    logic        read_ok;
    logic [7:0]  read_data;
  } elu_res_t;

endpackage

// File: rtl/core/elu_in_if.sv
// Input request channel: action, received byte and read index.
interface elu_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, output action, output rx_byte, output read_index,
                  input ready);
  modport sink   (input valid, input action, input rx_byte, input read_index,
                  output ready);
endinterface

// File: rtl/core/elu_out_if.sv
// Result channel: echo byte, line status and read data.
interface elu_out_if;
  logic       valid;
  logic       ready;
  logic       echo_valid;
  logic [7:0] echo_byte;
  logic       last;
  logic [7:0] returned_char;
  logic       line_ready;
  logic [7:0] line_length;
  logic       reset_request;
  logic       read_ok;
  logic [7:0] read_data;

  modport source (output valid, output echo_valid, output echo_byte, output last,
                  output returned_char, output line_ready, output line_length,
                  output reset_request, output read_ok, output read_data,
                  input ready);
  modport sink   (input valid, input echo_valid, input echo_byte, input last,
                  input returned_char, input line_ready, input line_length,
                  input reset_request, input read_ok, input read_data,
                  output ready);
endinterface

// File: rtl/core/elu_front.sv
// Front end: accepts requests, edits the line state and banks, classifies the echo.
module elu_front
  import elu_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF,
  parameter int MAX_LINE   = MAX_LINE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  elu_in_if.sink     in_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  output logic       q_push,
  output elu_cmd_t   q_data,
  input  logic       q_full
);

  localparam int ADDR_W = $clog2(LINE_DEPTH);
  localparam int LEN_W  = $clog2(LINE_DEPTH + 1);
  localparam int MEM_DEPTH = 2 ** (ADDR_W + 1);

  logic [7:0] line_mem [MEM_DEPTH];

  logic             echo_mode_r;
  logic             bank_r, bank_nxt;
  logic [LEN_W-1:0] edit_len_r, edit_len_nxt;
  logic [LEN_W-1:0] sub_len_r, sub_len_nxt;
  logic             ready_r, ready_nxt;
  logic             s1_vld_r, s1_vld_nxt;
  elu_cmd_t         s1_cmd_r, cmd_nxt;
  logic             s1_hit_r, hit_nxt;
  logic [7:0]       rdata_r;
  logic             mem_we;
  logic             acc;
  logic [ADDR_W:0]  wr_addr, rd_addr;

  assign in_ch.ready = !s1_vld_r || !q_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign q_push      = s1_vld_r && !q_full;
  assign s1_vld_nxt  = acc || (s1_vld_r && q_full);

  assign wr_addr = {bank_r, ADDR_W'(edit_len_r)};
  assign rd_addr = {~bank_r, ADDR_W'(in_ch.read_index)};

  always_comb begin
    q_data = s1_cmd_r;
    q_data.read_data = s1_hit_r ? rdata_r : 8'd0;
  end

  always_comb begin
    bank_nxt     = bank_r;
    edit_len_nxt = edit_len_r;
    sub_len_nxt  = sub_len_r;
    ready_nxt    = ready_r;
    mem_we       = 1'b0;
    hit_nxt      = 1'b0;
    cmd_nxt      = '0;
    unique case (in_ch.action)
      ACT_RX: begin
        cmd_nxt.rx_char = in_ch.rx_byte;
        cmd_nxt.rst_req = (in_ch.rx_byte == CH_CTRL_C) || (in_ch.rx_byte == CH_CTRL_D);
        if (echo_mode_r) begin
          if (in_ch.rx_byte >= CH_SPACE && in_ch.rx_byte <= CH_TILDE) begin
            if (int'(edit_len_r) < MAX_LINE && int'(edit_len_r) < LINE_DEPTH) begin
              mem_we       = 1'b1;
              edit_len_nxt = edit_len_r + LEN_W'(1);
              cmd_nxt.kind = ECHO_CHAR;
            end
          end else if (in_ch.rx_byte == CH_DEL) begin
            if (edit_len_r != '0) begin
              edit_len_nxt = edit_len_r - LEN_W'(1);
              cmd_nxt.kind = ECHO_DEL;
            end
          end else if (in_ch.rx_byte == CH_CR) begin
            cmd_nxt.kind = ECHO_CR;
            sub_len_nxt  = edit_len_r;
            bank_nxt     = ~bank_r;
            edit_len_nxt = '0;
            ready_nxt    = 1'b1;
          end
        end
      end
      ACT_READ: begin
        cmd_nxt.read_ok = ready_r;
        hit_nxt = ready_r && (int'(in_ch.read_index) < int'(sub_len_r));
      end
      ACT_RELEASE: begin
        ready_nxt   = 1'b0;
        sub_len_nxt = '0;
      end
      default: ;
    endcase
    cmd_nxt.line_ready = ready_nxt;
    cmd_nxt.line_len   = ready_nxt ? 8'(sub_len_nxt) : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_mode_r <= 1'b1;
      bank_r      <= 1'b0;
      edit_len_r  <= '0;
      sub_len_r   <= '0;
      ready_r     <= 1'b0;
      s1_vld_r    <= 1'b0;
    end else begin
      if (cfg_we) echo_mode_r <= cfg_wdata;
      if (acc) begin
        bank_r     <= bank_nxt;
        edit_len_r <= edit_len_nxt;
        sub_len_r  <= sub_len_nxt;
        ready_r    <= ready_nxt;
      end
      s1_vld_r <= s1_vld_nxt;
    end
  end

  // write bank and read bank always differ, so no same-address collision
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cmd_r <= cmd_nxt;
      s1_hit_r <= hit_nxt;
      rdata_r  <= line_mem[rd_addr];
      if (mem_we) line_mem[wr_addr] <= in_ch.rx_byte;
    end
  end

endmodule

// File: rtl/core/elu_queue.sv
// Short command queue between front and back ends.
module elu_queue
  import elu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  elu_cmd_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     head_vld,
  output elu_cmd_t head
);

  elu_cmd_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]     count_r, count_nxt;

  assign full     = (int'(count_r) == QUEUE_DEPTH);
  assign head_vld = (count_r != '0);
  assign head     = slots[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + (QUEUE_AW+1)'(1);
    else if (!push && pop) count_nxt = count_r - (QUEUE_AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr_r] <= push_data;
  end

endmodule

// File: rtl/core/elu_back.sv
// Back end: expands each command into one or three results behind an output register.
module elu_back
  import elu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_vld,
  input  elu_cmd_t head,
  output logic     pop,
  elu_out_if.source out_ch
);

  logic       out_vld_r;
  elu_res_t   res_r, res_nxt;
  logic [1:0] step_r;
  logic       can_load, load, last_step;

  assign can_load  = !out_vld_r || out_ch.ready;
  assign load      = can_load && head_vld;
  assign last_step = ((head.kind == ECHO_DEL) || (head.kind == ECHO_CR)) ?
                     (step_r == LAST_STEP) : 1'b1;
  assign pop       = load && last_step;

  always_comb begin
    res_nxt = '0;
    res_nxt.echo_valid    = (head.kind != ECHO_NONE);
    res_nxt.last          = last_step;
    res_nxt.returned_char = head.rx_char;
    res_nxt.line_ready    = head.line_ready;
    res_nxt.line_length   = head.line_len;
    res_nxt.reset_request = head.rst_req;
    res_nxt.read_ok       = head.read_ok;
    res_nxt.read_data     = head.read_data;
    unique case (head.kind)
      ECHO_NONE: res_nxt.echo_byte = 8'd0;
      ECHO_CHAR: res_nxt.echo_byte = head.rx_char;
      ECHO_DEL:  res_nxt.echo_byte = (step_r == 2'd1) ? CH_SPACE : CH_BS;
      ECHO_CR:   res_nxt.echo_byte = (step_r == 2'd0) ? CH_LF : CH_CR;
      default:   res_nxt.echo_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      step_r    <= 2'd0;
    end else begin
      if (can_load) out_vld_r <= head_vld;
      if (load) step_r <= last_step ? 2'd0 : step_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res_nxt;
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.echo_valid    = res_r.echo_valid;
  assign out_ch.echo_byte     = res_r.echo_byte;
  assign out_ch.last          = res_r.last;
  assign out_ch.returned_char = res_r.returned_char;
  assign out_ch.line_ready    = res_r.line_ready;
  assign out_ch.line_length   = res_r.line_length;
  assign out_ch.reset_request = res_r.reset_request;
  assign out_ch.read_ok       = res_r.read_ok;
  assign out_ch.read_data     = res_r.read_data;

endmodule

// File: rtl/core/echoing_line_editor_unit.sv
// Top level of the echoing line editor: front end, command queue, back end.
// A request passes the front-end stage register, the command queue and the output register.
// Throughput: one request per cycle into the front end while the queue has room;
// results leave one per cycle unless stalled; a request yields one (plain) or three (DEL, CR).
// Reset (synchronous, rst_n low) clears line state and queues and sets echo mode;
// the line memory is not cleared and needs no clearing pass.
module echoing_line_editor_unit
  import elu_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF,
  parameter int MAX_LINE   = MAX_LINE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  elu_in_if.sink     in_ch,
  elu_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  logic     q_push, q_full, q_pop, q_vld;
  elu_cmd_t q_wdata, q_head;

  elu_front #(
    .LINE_DEPTH (LINE_DEPTH),
    .MAX_LINE   (MAX_LINE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  elu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .head_vld  (q_vld),
    .head      (q_head)
  );

  elu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_vld (q_vld),
    .head     (q_head),
    .pop      (q_pop),
    .out_ch   (out_ch)
  );

endmodule

// File: verif/testbench.sv
// Testbench for echoing_line_editor_unit: directed table, random line traffic, scoreboard.
module testbench
  import elu_pkg::*;
();

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  elu_in_if  in_ch ();
  elu_out_if out_ch ();

  echoing_line_editor_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // shadow of the editor state
  logic [7:0] line_mem [0:2*LINE_DEPTH_DEF-1];
  bit         ed_bank   = 1'b0;
  int         ed_len    = 0;
  int         sub_len   = 0;
  bit         line_rdy  = 1'b0;
  bit         mode_echo = 1'b1;

  elu_res_t   step_out [$];
  elu_res_t   line_results_q [$];

  int         err_count   = 0;
  int         sent_count  = 0;
  int         burst_left  = 0;
  int         hold_seq    = 0;
  int         hold_done   = 0;

  typedef struct {
    logic [1:0] act;
    logic [7:0] rx;
    logic [7:0] idx;
    bit         typed;
    logic [7:0] rc;
    logic       rdy;
    logic [7:0] len;
    logic       rr;
    logic       ok;
    logic [7:0] data;
  } stim_row_t;

  // typed rows carry a single result with no echo
  stim_row_t dir_rows [25] = '{
    '{ACT_READ,    8'h00,     8'h00, 1'b1, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_RELEASE, 8'hFF,     8'hFF, 1'b1, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_UNUSED,  8'hFF,     8'hFF, 1'b1, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_RX,      CH_CTRL_C, 8'h00, 1'b1, 8'd3,   1'b0, 8'd0, 1'b1, 1'b0, 8'd0},
    '{ACT_RX,      CH_CTRL_D, 8'h00, 1'b1, 8'd4,   1'b0, 8'd0, 1'b1, 1'b0, 8'd0},
    '{ACT_RX,      8'h00,     8'hFF, 1'b1, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_RX,      CH_DEL,    8'h00, 1'b1, 8'd127, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_RX,      8'hFF,     8'h00, 1'b1, 8'd255, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_RX,      8'd31,     8'h00, 1'b1, 8'd31,  1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_RX,      CH_SPACE,  8'h00, 1'b0, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_RX,      CH_TILDE,  8'h00, 1'b0, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_RX,      8'h41,     8'h00, 1'b0, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_RX,      CH_DEL,    8'h00, 1'b0, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_RX,      8'h55,     8'h00, 1'b0, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_RX,      CH_CR,     8'h00, 1'b0, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_READ,    8'h00,     8'd0,  1'b0, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_READ,    8'h00,     8'd2,  1'b0, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_READ,    8'h00,     8'd3,  1'b1, 8'd0,   1'b1, 8'd3, 1'b0, 1'b1, 8'd0},
    '{ACT_READ,    8'h00,     8'hFF, 1'b1, 8'd0,   1'b1, 8'd3, 1'b0, 1'b1, 8'd0},
    '{ACT_RX,      8'h42,     8'h00, 1'b0, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_RX,      CH_CR,     8'h00, 1'b0, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_READ,    8'h00,     8'd0,  1'b0, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_RELEASE, 8'h00,     8'h00, 1'b0, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_RELEASE, 8'h00,     8'h00, 1'b1, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ACT_RX,      CH_CR,     8'h00, 1'b0, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 8'd0}
  };

  function automatic void edit_line_and_echo(input logic [1:0] act, input logic [7:0] b,
                                             input logic [7:0] idx);
    elu_res_t   r;
    logic [7:0] echo [3];
    int         n;
    n = 0;
    r = '0;
    step_out.delete();
    case (act)
      ACT_RX: begin
        if (mode_echo) begin
          if (b >= CH_SPACE && b <= CH_TILDE) begin
            if (ed_len < MAX_LINE_DEF) begin
              line_mem[ed_bank * LINE_DEPTH_DEF + ed_len] = b;
              ed_len++;
              echo[0] = b;
              n = 1;
            end
          end else if (b == CH_DEL) begin
            if (ed_len > 0) begin
              ed_len--;
              echo = '{CH_BS, CH_SPACE, CH_BS};
              n = 3;
            end
          end else if (b == CH_CR) begin
            echo = '{CH_LF, CH_CR, CH_CR};
            n = 3;
            sub_len = ed_len;
            ed_bank = ~ed_bank;
            ed_len = 0;
            line_rdy = 1'b1;
          end
        end
        r.returned_char = b;
        r.reset_request = (b == CH_CTRL_C || b == CH_CTRL_D);
      end
      ACT_READ: begin
        r.read_ok = line_rdy;
        // submitted line sits in the bank not being edited
        if (line_rdy && idx < sub_len)
          r.read_data = line_mem[(ed_bank ? 0 : LINE_DEPTH_DEF) + idx];
      end
      ACT_RELEASE: begin
        if (line_rdy) begin
          line_rdy = 1'b0;
          sub_len = 0;
        end
      end
      default: ;
    endcase
    r.line_ready = line_rdy;
    r.line_length = line_rdy ? 8'(sub_len) : 8'd0;
    if (n == 0) begin
      r.last = 1'b1;
      step_out.push_back(r);
    end else begin
      for (int k = 0; k < n; k++) begin
        r.echo_valid = 1'b1;
        r.echo_byte = echo[k];
        r.last = (k == n - 1);
        step_out.push_back(r);
      end
    end
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [7:0] read_pick();
    return ($urandom_range(0, 4) == 0) ? rnd8() : 8'($urandom_range(0, sub_len + 1));
  endfunction

  task automatic send_req(input logic [1:0] act, input logic [7:0] b, input logic [7:0] idx,
                          input bit typed = 1'b0, input elu_res_t pinned = '0);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.rx_byte    <= b;
    in_ch.read_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    sent_count++;
    edit_line_and_echo(act, b, idx);
    if (typed)
      line_results_q.push_back(pinned);
    else
      foreach (step_out[k]) line_results_q.push_back(step_out[k]);
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (line_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input bit m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mode_echo = m;
  endtask

  task automatic run_phase(input bit m, input int n_items, input bit with_hold);
    int stop_at;
    int len;
    stop_at = sent_count + n_items;
    quiesce();
    write_mode(m);
    // long receiver hold-off so the request side backs up
    if (with_hold) hold_seq <= hold_seq + 1;
    while (sent_count < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          len = $urandom_range(0, 14);
          repeat (len)
            send_req(ACT_RX, ($urandom_range(0, 5) == 0) ? CH_DEL : printable(), rnd8());
          send_req(ACT_RX, CH_CR, rnd8());
          repeat ($urandom_range(1, 4)) send_req(ACT_READ, rnd8(), read_pick());
          if ($urandom_range(0, 3) != 0) send_req(ACT_RELEASE, rnd8(), rnd8());
        end
        6, 7: begin
          repeat ($urandom_range(1, 4)) send_req(2'($urandom_range(0, 3)), rnd8(), rnd8());
        end
        8: begin
          // unfinished line, then rubouts that may outnumber its bytes
          len = $urandom_range(1, 6);
          repeat (len) send_req(ACT_RX, printable(), rnd8());
          repeat ($urandom_range(0, 8)) send_req(ACT_RX, CH_DEL, rnd8());
        end
        default: begin
          // second submit while the first line still waits
          repeat ($urandom_range(0, 5)) send_req(ACT_RX, printable(), rnd8());
          send_req(ACT_RX, CH_CR, rnd8());
          repeat ($urandom_range(0, 5)) send_req(ACT_RX, printable(), rnd8());
          send_req(ACT_RX, CH_CR, rnd8());
          send_req(ACT_READ, rnd8(), read_pick());
        end
      endcase
    end
  endtask

  function automatic void cmp_field(input string f, input logic [7:0] want,
                                    input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, f, want, got);
      err_count++;
    end
  endfunction

  task automatic take_result();
    elu_res_t want;
    if (line_results_q.size() == 0) begin
      $display("%0t: result with nothing pending, echo_byte %0d", $time, out_ch.echo_byte);
      err_count++;
      return;
    end
    want = line_results_q.pop_front();
    cmp_field("echo_valid",    want.echo_valid,    out_ch.echo_valid);
    cmp_field("echo_byte",     want.echo_byte,     out_ch.echo_byte);
    cmp_field("last",          want.last,          out_ch.last);
    cmp_field("returned_char", want.returned_char, out_ch.returned_char);
    cmp_field("line_ready",    want.line_ready,    out_ch.line_ready);
    cmp_field("line_length",   want.line_length,   out_ch.line_length);
    cmp_field("reset_request", want.reset_request, out_ch.reset_request);
    cmp_field("read_ok",       want.read_ok,       out_ch.read_ok);
    cmp_field("read_data",     want.read_data,     out_ch.read_data);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) take_result();
    end
  end

  // receiver back-pressure
  initial begin
    int span;
    int mode;
    int hold;
    span = 0;
    mode = 0;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_done) begin
        hold = 120;
        hold_done = hold_seq;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(5, 40);
      end
      span--;
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= (span % 4 == 0);
        endcase
      end
    end
  end

  initial begin
    elu_res_t pin;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_RX;
    in_ch.rx_byte    = 8'd0;
    in_ch.read_index = 8'd0;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    rst_n            = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(1'b1);

    foreach (dir_rows[i]) begin
      pin = '0;
      pin.last          = 1'b1;
      pin.returned_char = dir_rows[i].rc;
      pin.line_ready    = dir_rows[i].rdy;
      pin.line_length   = dir_rows[i].len;
      pin.reset_request = dir_rows[i].rr;
      pin.read_ok       = dir_rows[i].ok;
      pin.read_data     = dir_rows[i].data;
      send_req(dir_rows[i].act, dir_rows[i].rx, dir_rows[i].idx, dir_rows[i].typed, pin);
    end

    run_phase(1'b0, 20, 1'b0);
    run_phase(1'b1, 60, 1'b1);
    run_phase(1'b0, 15, 1'b0);
    run_phase(1'b1, 30, 1'b0);
    quiesce();
    repeat (10) @(posedge clk);

    if (err_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #200000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
